// ===== sv/assert_macros.svh =====
// Assertion macros shared by the rotator RTL.
// Plain text macros only; no package or module dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

// ===== sv/iqtr_pkg.sv =====
// Package for the quarter-turn rotator: field widths, codes, config and control types.
// No dependencies.
`timescale 1ns / 1ps

package iqtr_pkg;

  localparam int CoordW      = 6;
  localparam int PixW        = 24;
  localparam int RegW        = 7;
  localparam int TurnW       = 2;
  localparam int CfgIdxW     = 3;
  localparam int StatusW     = 2;

  localparam int DefMaxRows   = 64;
  localparam int DefMaxCols   = 64;
  localparam int DefPixelBits = 24;

  localparam logic [RegW-1:0] RstImageRows = 7'd64;
  localparam logic [RegW-1:0] RstImageCols = 7'd64;
  localparam logic [RegW-1:0] RstSelRight  = 7'd64;
  localparam logic [RegW-1:0] RstSelBottom = 7'd64;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_SQUARE = 2'd1,
    ST_OUTSIDE    = 2'd2
  } status_e;

  typedef enum logic [TurnW-1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TURNS      = 3'd0,
    REG_IMAGE_ROWS = 3'd1,
    REG_IMAGE_COLS = 3'd2,
    REG_SEL_LEFT   = 3'd3,
    REG_SEL_RIGHT  = 3'd4,
    REG_SEL_TOP    = 3'd5,
    REG_SEL_BOTTOM = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    turn_e           turns;
    logic [RegW-1:0] image_rows;
    logic [RegW-1:0] image_cols;
    logic [RegW-1:0] sel_left;
    logic [RegW-1:0] sel_right;
    logic [RegW-1:0] sel_top;
    logic [RegW-1:0] sel_bottom;
  } cfg_t;

  // Per-access control from the address mapper.
  typedef struct packed {
    status_e status;
    logic    wr_en;
    logic    rd_en;
  } ctl_t;

endpackage

// ===== sv/iqtr_if.sv =====
// Valid/ready channel interfaces: access requests, results and config writes.
// Depends on iqtr_pkg.
`timescale 1ns / 1ps

interface iqtr_req_if;
  logic                         valid;
  logic                         ready;
  iqtr_pkg::cmd_e               cmd;
  logic [iqtr_pkg::CoordW-1:0]  row;
  logic [iqtr_pkg::CoordW-1:0]  col;
  logic [iqtr_pkg::PixW-1:0]    pixel_in;

  modport source (output valid, cmd, row, col, pixel_in, input ready);
  modport sink   (input valid, cmd, row, col, pixel_in, output ready);
endinterface

interface iqtr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [iqtr_pkg::PixW-1:0]    pixel_out;
  logic [iqtr_pkg::StatusW-1:0] status;

  modport source (output valid, pixel_out, status, input ready);
  modport sink   (input valid, pixel_out, status, output ready);
endinterface

interface iqtr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [iqtr_pkg::CfgIdxW-1:0] index;
  logic [iqtr_pkg::RegW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/image_quarter_turn_rotator.sv =====
// Top level of the quarter-turn rotator: config registers, access pipeline, frame store.
// Depends on iqtr_pkg, iqtr_if.sv, iqtr_map and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Frame store with a rotated read view.
// req_i  : access requests. cmd write stores pixel_in at (row, col) of the stored
//          image; cmd read fetches (row, col) of the view turned clockwise by
//          quarter_turns. A request is taken when valid and ready are both high.
// rsp_o  : one result per request, in order: pixel_out (zero for writes and for
//          accesses outside the image) and status (ok / not square / outside).
// cfg_i  : register writes, index 0..6 = quarter_turns, image_rows, image_cols,
//          sel_left, sel_right, sel_top, sel_bottom. Always ready; indexes past
//          the list are dropped. Write only while no request is in flight.
// Timing : two-stage pipeline. Stage A holds the request and maps it to a store
//          address; the memory port writes, or reads into the result register,
//          as A moves into stage B, which raises rsp_o.valid; a request passes
//          through the A register and then the B register before its result
//          is offered. Throughput one request per cycle while rsp_o is not
//          stalled, set by the single read/write port of the frame store.
// Stall  : a stalled rsp_o holds stage B; stage A still takes one more request,
//          after which req_i.ready drops until the result is taken.
// Reset  : pipeline empties and registers return to a full 64x64 unrotated view.
//          Store contents are undefined until written; there is no clear pass.
module image_quarter_turn_rotator #(
  parameter int MAX_ROWS   = iqtr_pkg::DefMaxRows,
  parameter int MAX_COLS   = iqtr_pkg::DefMaxCols,
  parameter int PIXEL_BITS = iqtr_pkg::DefPixelBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iqtr_req_if.sink   req_i,
  iqtr_rsp_if.source rsp_o,
  iqtr_cfg_if.sink   cfg_i
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(Depth);

  // ---------------- config registers ----------------
  iqtr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (iqtr_pkg::cfg_reg_e'(cfg_i.index))
        iqtr_pkg::REG_TURNS:      cfg_d.turns      = iqtr_pkg::turn_e'(cfg_i.data[iqtr_pkg::TurnW-1:0]);
        iqtr_pkg::REG_IMAGE_ROWS: cfg_d.image_rows = cfg_i.data;
        iqtr_pkg::REG_IMAGE_COLS: cfg_d.image_cols = cfg_i.data;
        iqtr_pkg::REG_SEL_LEFT:   cfg_d.sel_left   = cfg_i.data;
        iqtr_pkg::REG_SEL_RIGHT:  cfg_d.sel_right  = cfg_i.data;
        iqtr_pkg::REG_SEL_TOP:    cfg_d.sel_top    = cfg_i.data;
        iqtr_pkg::REG_SEL_BOTTOM: cfg_d.sel_bottom = cfg_i.data;
        default: ;  // unused index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turns      <= iqtr_pkg::TURN_0;
      cfg_q.image_rows <= iqtr_pkg::RstImageRows;
      cfg_q.image_cols <= iqtr_pkg::RstImageCols;
      cfg_q.sel_left   <= '0;
      cfg_q.sel_right  <= iqtr_pkg::RstSelRight;
      cfg_q.sel_top    <= '0;
      cfg_q.sel_bottom <= iqtr_pkg::RstSelBottom;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- stage A: request register ----------------
  logic                        a_valid_q, a_valid_d;
  iqtr_pkg::cmd_e              a_cmd_q;
  logic [iqtr_pkg::CoordW-1:0] a_row_q, a_col_q;
  logic [iqtr_pkg::PixW-1:0]   a_pix_q;

  // ---------------- stage B: result register ----------------
  logic                        b_valid_q, b_valid_d;
  iqtr_pkg::status_e           b_status_q;
  logic                        b_rd_q;
  logic [PIXEL_BITS-1:0]       mem_rd_q;

  logic                        adv_b;    // stage B can take what A holds
  logic                        req_acc;
  logic [AW-1:0]               mem_addr;
  iqtr_pkg::ctl_t              ctl;

  assign adv_b       = !b_valid_q || rsp_o.ready;
  assign req_i.ready = !a_valid_q || adv_b;
  assign req_acc     = req_i.valid && req_i.ready;

  assign a_valid_d = req_acc ? 1'b1 : (adv_b ? 1'b0 : a_valid_q);
  assign b_valid_d = adv_b ? a_valid_q : b_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      a_cmd_q <= req_i.cmd;
      a_row_q <= req_i.row;
      a_col_q <= req_i.col;
      a_pix_q <= req_i.pixel_in;
    end
  end

  iqtr_map #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_map (
    .cmd_i  (a_cmd_q),
    .row_i  (a_row_q),
    .col_i  (a_col_q),
    .cfg_i  (cfg_q),
    .addr_o (mem_addr),
    .ctl_o  (ctl)
  );

  // ---------------- frame store ----------------
  // One port: write or registered read, both on the A-to-B move.
  logic [PIXEL_BITS-1:0] frame_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (a_valid_q && adv_b) begin
      if (ctl.wr_en) frame_mem[mem_addr] <= PIXEL_BITS'(a_pix_q);
      if (ctl.rd_en) mem_rd_q <= frame_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && adv_b) begin
      b_status_q <= ctl.status;
      b_rd_q     <= ctl.rd_en;
    end
  end

  assign rsp_o.valid     = b_valid_q;
  assign rsp_o.status    = b_status_q;
  assign rsp_o.pixel_out = b_rd_q ? iqtr_pkg::PixW'(mem_rd_q) : '0;

  // ---------------- checks ----------------
  `ASSERT_AT(a_outside_no_mem, clk_i, rst_ni,
    a_valid_q && ctl.status == iqtr_pkg::ST_OUTSIDE |-> !ctl.wr_en && !ctl.rd_en,
    "outside access touches the frame store")
  `ASSERT_AT(a_accept_fills_a, clk_i, rst_ni,
    req_i.valid && req_i.ready |=> a_valid_q,
    "accepted request missing from stage A")
  `ASSERT_AT(a_empty_b_ready, clk_i, rst_ni,
    !b_valid_q |-> req_i.ready,
    "request blocked with result stage empty")
  `ASSERT_NEVER(a_addr_range, clk_i, rst_ni,
    a_valid_q && (ctl.wr_en || ctl.rd_en) && (32'(mem_addr) >= Depth),
    "store address past the frame")

endmodule

// ===== sv/iqtr_map.sv =====
// Address mapper: turns a view coordinate into a frame store address plus status.
// Depends on iqtr_pkg. Purely combinational.
`timescale 1ns / 1ps

module iqtr_map #(
  parameter int MAX_ROWS = iqtr_pkg::DefMaxRows,
  parameter int MAX_COLS = iqtr_pkg::DefMaxCols,
  parameter int AW       = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  iqtr_pkg::cmd_e              cmd_i,
  input  logic [iqtr_pkg::CoordW-1:0] row_i,
  input  logic [iqtr_pkg::CoordW-1:0] col_i,
  input  iqtr_pkg::cfg_t              cfg_i,
  output logic [AW-1:0]               addr_o,
  output iqtr_pkg::ctl_t              ctl_o
);

  localparam int MaxDim  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DimBits = $clog2(MaxDim + 1);
  localparam int DimW    = (DimBits > iqtr_pkg::RegW) ? DimBits : iqtr_pkg::RegW;

  logic [DimW-1:0] rows, cols, left, right, top, bottom, r, c;
  logic [DimW-1:0] vr, vc, n, h, w, lr, lc, br, bc, mr, mc, sr, sc;
  logic            full_sel, square, in_img, in_view, in_sel;
  iqtr_pkg::turn_e rot_turns;

  // image size saturates at the store dimensions
  assign rows = (DimW'(cfg_i.image_rows) > DimW'(MAX_ROWS)) ? DimW'(MAX_ROWS)
                                                            : DimW'(cfg_i.image_rows);
  assign cols = (DimW'(cfg_i.image_cols) > DimW'(MAX_COLS)) ? DimW'(MAX_COLS)
                                                            : DimW'(cfg_i.image_cols);
  assign left   = DimW'(cfg_i.sel_left);
  assign right  = DimW'(cfg_i.sel_right);
  assign top    = DimW'(cfg_i.sel_top);
  assign bottom = DimW'(cfg_i.sel_bottom);
  assign r      = DimW'(row_i);
  assign c      = DimW'(col_i);

  assign full_sel = (left == '0) && (top == '0) &&
                    (cfg_i.sel_right == cfg_i.image_cols) &&
                    (cfg_i.sel_bottom == cfg_i.image_rows) &&
                    (right == cols) && (bottom == rows);
  assign square   = (left <= right) && (top <= bottom) && (right <= cols) &&
                    (bottom <= rows) && ((right - left) == (bottom - top));
  assign n        = right - left;

  assign vr      = cfg_i.turns[0] ? cols : rows;
  assign vc      = cfg_i.turns[0] ? rows : cols;
  assign in_img  = (r < rows) && (c < cols);
  assign in_view = (r < vr) && (c < vc);
  assign in_sel  = (r >= top) && (r < bottom) && (c >= left) && (c < right);

  always_comb begin
    ctl_o     = '{status: iqtr_pkg::ST_OK, wr_en: 1'b0, rd_en: 1'b0};
    rot_turns = iqtr_pkg::TURN_0;
    h         = rows;
    w         = cols;
    lr        = r;
    lc        = c;
    br        = '0;
    bc        = '0;
    if (cmd_i == iqtr_pkg::CMD_WRITE) begin
      if (in_img) ctl_o.wr_en = 1'b1;
      else        ctl_o.status = iqtr_pkg::ST_OUTSIDE;
    end else if (full_sel) begin
      // whole image turns; view dims swap on odd turns
      if (in_view) begin
        ctl_o.rd_en = 1'b1;
        rot_turns   = cfg_i.turns;
      end else begin
        ctl_o.status = iqtr_pkg::ST_OUTSIDE;
      end
    end else if (!in_img) begin
      ctl_o.status = iqtr_pkg::ST_OUTSIDE;
    end else if (!square) begin
      ctl_o.status = iqtr_pkg::ST_NOT_SQUARE;
      ctl_o.rd_en  = 1'b1;
    end else begin
      ctl_o.rd_en = 1'b1;
      if (in_sel) begin
        rot_turns = cfg_i.turns;
        h         = n;
        w         = n;
        lr        = r - top;
        lc        = c - left;
        br        = top;
        bc        = left;
      end
    end
  end

  // clockwise turn: view (lr,lc) to source coordinate within an h x w window
  always_comb begin
    case (rot_turns)
      iqtr_pkg::TURN_90: begin
        mr = h - 1'b1 - lc;
        mc = lr;
      end
      iqtr_pkg::TURN_180: begin
        mr = h - 1'b1 - lr;
        mc = w - 1'b1 - lc;
      end
      iqtr_pkg::TURN_270: begin
        mr = lc;
        mc = w - 1'b1 - lr;
      end
      default: begin
        mr = lr;
        mc = lc;
      end
    endcase
  end

  assign sr     = br + mr;
  assign sc     = bc + mc;
  assign addr_o = AW'(32'(sr) * 32'(MAX_COLS) + 32'(sc));

endmodule
